@@ rtl/bol_pkg.sv @@
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and constants for the bounded ordered list unit: command and
// result payloads, operation codes and the default list capacity.
// ----------------------------------------------------------------------------
package bol_pkg;

	localparam int CAPACITY_DEFAULT = 16;

	localparam logic [1:0] OP_INS_FRONT = 2'd0;
	localparam logic [1:0] OP_INS_BACK  = 2'd1;
	localparam logic [1:0] OP_DELETE    = 2'd2;

	typedef struct packed {
		logic        [1:0]  operation;
		logic signed [31:0] value;
		logic        [7:0]  position;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] entry_value;
		logic               is_last;
		logic               list_empty;
		logic               insert_dropped;
	} rsp_t;

endpackage

@@ rtl/bounded_ordered_list_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit
// Ordered list of signed 32-bit values held in a circular buffer in one
// synchronous RAM; every command is followed by a dump of the whole list.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one operation per
//   transfer: insert at front, insert at back, or delete at a position.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns the list after the
//   operation, one entry per transfer from the front, is_last on the final
//   one. An empty list returns a single transfer with list_empty set.
//   A full list drops inserts and flags insert_dropped on the whole dump.
// Timing:
//   Inserts write the RAM in the accept cycle (head pointer moves for a
//   front insert). The dump then reads one entry per cycle while the result
//   register is free, through the RAM read port, whose registered output is
//   the result register; the first result follows the move into the dump
//   state and the RAM read. A delete is folded into the dump: entries past
//   the hole are read one place further on and written back one place lower,
//   each in the cycle after its read. A trailing write-back after a delete
//   ends the item before the next command is taken.
// Reset clears count, head pointer and output valid; the RAM needs no clear.
// A stalled result holds and the dump pauses until the receiver takes it.
// ----------------------------------------------------------------------------
module bounded_ordered_list_unit #(
	parameter int CAPACITY = bol_pkg::CAPACITY_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  bol_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bol_pkg::rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_W  = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [AW-1:0] TOP_IX = AW'(CAPACITY - 1);

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	// Physical slot of a logical offset from the head, wrapping at CAPACITY.
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= CAP_W) begin
			sum = sum - CAP_W;
		end
		return sum[AW-1:0];
	endfunction

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] k_q;
	logic          del_act_q;
	logic [AW-1:0] del_pos_q;
	logic          drop_q;
	logic          wr_pend_q;
	logic [AW-1:0] wr_addr_q;
	logic          rsp_valid_q;
	logic          rsp_last_q;
	logic          rsp_empty_q;
	logic          rsp_drop_q;
	logic [31:0]   rd_q;

	logic [31:0]   mem [CAPACITY];

	logic          cmd_acc;
	logic          is_insert;
	logic          full;
	logic [AW-1:0] head_dec;
	logic          pos_ok;
	logic          issue;
	logic          past_hole;
	logic [AW-1:0] src_off;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic          last_k;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;

	// Accept only in idle and after the trailing delete write-back.
	assign cmd_stall = !(state_q == ST_IDLE && !wr_pend_q);
	assign cmd_acc   = cmd_valid && !cmd_stall;

	assign is_insert = (cmd.operation == bol_pkg::OP_INS_FRONT) ||
	                   (cmd.operation == bol_pkg::OP_INS_BACK);
	assign full      = (count_q == CAP_C);
	assign head_dec  = (head_q == '0) ? TOP_IX : head_q - 1'b1;
	assign pos_ok    = (9'(cmd.position) < 9'(count_q));

	// Dump side: advance one entry whenever the result register is free.
	assign issue     = (state_q == ST_DUMP) && (!rsp_valid_q || !rsp_stall);
	assign past_hole = del_act_q && (k_q >= del_pos_q);
	assign src_off   = past_hole ? k_q + 1'b1 : k_q;
	assign rd_addr   = wrap_add(head_q, src_off);
	assign rd_en     = issue && (count_q != '0);
	assign last_k    = ((CW'(k_q) + 1'b1) == count_q);

	// Write port: trailing delete write-back, else an accepted insert.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = cmd.value;
		if (wr_pend_q) begin
			wr_en   = 1'b1;
			wr_addr = wr_addr_q;
			wr_data = rd_q;
		end else if (cmd_acc && is_insert && !full) begin
			wr_en = 1'b1;
			if (cmd.operation == bol_pkg::OP_INS_FRONT) begin
				wr_addr = head_dec;
			end else begin
				wr_addr = wrap_add(head_q, count_q[AW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			k_q         <= '0;
			del_act_q   <= 1'b0;
			del_pos_q   <= '0;
			drop_q      <= 1'b0;
			wr_pend_q   <= 1'b0;
			wr_addr_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_last_q  <= 1'b0;
			rsp_empty_q <= 1'b0;
			rsp_drop_q  <= 1'b0;
		end else begin
			wr_pend_q <= 1'b0;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q   <= ST_DUMP;
						k_q       <= '0;
						drop_q    <= 1'b0;
						del_act_q <= 1'b0;
						del_pos_q <= cmd.position[AW-1:0];
						case (cmd.operation)
							bol_pkg::OP_INS_FRONT: begin
								if (full) begin
									drop_q <= 1'b1;
								end else begin
									head_q  <= head_dec;
									count_q <= count_q + 1'b1;
								end
							end
							bol_pkg::OP_INS_BACK: begin
								if (full) begin
									drop_q <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							bol_pkg::OP_DELETE: begin
								if (pos_ok) begin
									del_act_q <= 1'b1;
									count_q   <= count_q - 1'b1;
								end
							end
							default: begin
								// unused code: list unchanged, dump only
							end
						endcase
					end
				end
				ST_DUMP: begin
					if (issue) begin
						rsp_valid_q <= 1'b1;
						rsp_drop_q  <= drop_q;
						if (count_q == '0) begin
							rsp_last_q  <= 1'b1;
							rsp_empty_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							rsp_last_q  <= last_k;
							rsp_empty_q <= 1'b0;
							k_q         <= k_q + 1'b1;
							if (past_hole) begin
								// close the hole: move the entry read now down one slot
								wr_pend_q <= 1'b1;
								wr_addr_q <= wrap_add(head_q, k_q);
							end
							if (last_k) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign rsp.entry_value    = rsp_empty_q ? '0 : rd_q;
	assign rsp.is_last        = rsp_last_q;
	assign rsp.list_empty     = rsp_empty_q;
	assign rsp.insert_dropped = rsp_drop_q;

endmodule

@@ rtl/bol_checker.sv @@
// ----------------------------------------------------------------------------
// bol_checker
// Port-level checks for the bounded ordered list unit, bound to the top level.
// ----------------------------------------------------------------------------
module bol_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input bol_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bol_pkg::rsp_t rsp
);

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// An accepted command blocks the next one while its dump runs.
	a_cmd_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command accepted during dump");

	// No command is taken while a dump is still in the middle of the list.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |-> !(rsp_valid && !rsp.is_last))
		else $error("command accepted mid-dump");

	// Dump entries follow back to back once a transfer completes.
	a_dump_cont: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.is_last |=> rsp_valid)
		else $error("gap inside dump");

	// Empty list gives one final zero result.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.list_empty |-> rsp.is_last && (rsp.entry_value == 0))
		else $error("bad empty-list result");

endmodule

bind bounded_ordered_list_unit bol_checker u_bol_checker (.*);

@@ bench/list_dump_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_dump_checker
// Watches the command and result channels of the ordered list unit, keeps
// its own copy of the list, queues the dump each command should produce and
// compares every result transfer against it.
// ----------------------------------------------------------------------------
module list_dump_checker #(
	parameter int CAPACITY = bol_pkg::CAPACITY_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  bol_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  bol_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);

	import bol_pkg::*;

	logic signed [31:0] list_vals [CAPACITY];
	int                 list_len;
	rsp_t               expected_dump [$];
	rsp_t               want;

	// Apply one operation to the shadow list and queue the dump it causes.
	task automatic apply_list_op(input cmd_t c);
		logic dropped;
		int   i;
		rsp_t r;
		dropped = 1'b0;
		case (c.operation)
			OP_INS_FRONT, OP_INS_BACK: begin
				if (list_len >= CAPACITY) begin
					dropped = 1'b1;
				end else if (c.operation == OP_INS_FRONT) begin
					for (i = list_len; i > 0; i--)
						list_vals[i] = list_vals[i - 1];
					list_vals[0] = c.value;
					list_len++;
				end else begin
					list_vals[list_len] = c.value;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (c.position < list_len) begin
					for (i = c.position; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
			end
			default: ;
		endcase

		if (list_len == 0) begin
			r.entry_value    = '0;
			r.is_last        = 1'b1;
			r.list_empty     = 1'b1;
			r.insert_dropped = dropped;
			expected_dump.push_back(r);
		end else begin
			for (i = 0; i < list_len; i++) begin
				r.entry_value    = list_vals[i];
				r.is_last        = (i + 1 == list_len);
				r.list_empty     = 1'b0;
				r.insert_dropped = dropped;
				expected_dump.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_dump.delete();
			list_len   = 0;
			fail_count = 0;
			pending   <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				apply_list_op(cmd);
			if (rsp_valid && !rsp_stall) begin
				if (expected_dump.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result value=%0d last=%b empty=%b drop=%b",
							$realtime, rsp.entry_value, rsp.is_last, rsp.list_empty,
							rsp.insert_dropped);
				end else begin
					want = expected_dump.pop_front();
					if (rsp.entry_value !== want.entry_value ||
						rsp.is_last !== want.is_last ||
						rsp.list_empty !== want.list_empty ||
						rsp.insert_dropped !== want.insert_dropped) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch, exp %0d l%b e%b d%b got %0d l%b e%b d%b",
								$realtime, want.entry_value, want.is_last, want.list_empty,
								want.insert_dropped, rsp.entry_value, rsp.is_last,
								rsp.list_empty, rsp.insert_dropped);
					end
				end
			end
			pending <= expected_dump.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bounded ordered list unit. A directed opening
// covers empty-list deletes, extreme values, out-of-range positions, filling
// to capacity and dropped inserts; random segments then fill, drain and mix
// the list under random sender gaps and receiver stalls. Result checking is
// done by list_dump_checker, instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_top;

	import bol_pkg::*;

	// Operation code the block does not define; it must leave the list alone.
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam int CAPACITY  = CAPACITY_DEFAULT;
	localparam int LIMIT     = 1000000;
	localparam int SEG_ITEMS = 26;
	localparam int SEGMENTS  = 6;

	typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_style_t;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_stall;
	cmd_t  cmd       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	int    fail_count;
	int    pending;
	int    cycle_count = 0;
	bit    burst_mode  = 1'b0;

	bounded_ordered_list_unit #(
		.CAPACITY (CAPACITY)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	list_dump_checker #(
		.CAPACITY (CAPACITY)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bail out if the run hangs; a correct run ends far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("[bounded_ordered_list_unit] ERROR");
			$finish;
		end
	end

	// Idle length: mostly back to back or short, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Bias values toward the signed extremes, otherwise full 32-bit random.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Receiver side: runs without stalls, separated by stalls that are now and
	// then long enough to back up the dump.
	initial begin
		int run_len;
		int hold_len;
		forever begin
			run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
			                                       : $urandom_range(0, 12);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
			                                       : $urandom_range(1, 3);
			repeat (run_len) begin
				@(posedge clk);
				rsp_stall <= 1'b0;
			end
			repeat (hold_len) begin
				@(posedge clk);
				rsp_stall <= 1'b1;
			end
		end
	end

	// Present one command and hold it until the transfer happens. Valid is
	// only lowered when a gap follows, so back-to-back commands keep it high.
	task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] val,
		input logic [7:0] pos);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.operation <= op;
		cmd.value     <= val;
		cmd.position  <= pos;
		cmd_valid     <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	// Drop valid and hold the sender until every queued dump has come back.
	// The first edge lets the checker count the last command's dump.
	task automatic wait_dump_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int         seg;
		int         n;
		int         r;
		int         ins_pct;
		logic [1:0] op;
		logic [7:0] pos;
		seg_style_t style;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: deletes and the reserved code on an empty list, extreme
		// values at both ends, positions at and past the count, back to empty.
		send_cmd(OP_DELETE, 32'sd0, 8'd0);
		send_cmd(OP_RESERVED, 32'sd0, 8'd0);
		send_cmd(OP_INS_FRONT, 32'sh7FFF_FFFF, 8'd0);
		send_cmd(OP_INS_BACK, 32'sh8000_0000, 8'd0);
		send_cmd(OP_DELETE, 32'sd0, 8'd255);
		send_cmd(OP_DELETE, 32'sd0, 8'd2);
		send_cmd(OP_DELETE, 32'sd0, 8'd0);
		send_cmd(OP_DELETE, 32'sd0, 8'd0);

		// Fill to capacity from both ends, then push two inserts that must drop.
		for (n = 0; n < CAPACITY; n++)
			send_cmd(n[0] ? OP_INS_BACK : OP_INS_FRONT, pick_value(), 8'd0);
		send_cmd(OP_INS_FRONT, 32'sd12345, 8'd0);
		send_cmd(OP_INS_BACK, -32'sd12345, 8'd0);

		wait_dump_idle();

		// Random segments: fill, drain and mixed in turn so the list keeps
		// swinging between empty and full. Some segments run with no gaps.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			style      = seg_style_t'(seg % 3);
			burst_mode = ($urandom_range(0, 3) == 0);
			case (style)
				SEG_FILL:  ins_pct = 80;
				SEG_DRAIN: ins_pct = 20;
				default:   ins_pct = 50;
			endcase
			for (n = 0; n < SEG_ITEMS; n++) begin
				r   = $urandom_range(0, 99);
				pos = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				                                  : 8'($urandom_range(0, CAPACITY + 1));
				if (r < ins_pct)
					op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
				else if (r < 96)
					op = OP_DELETE;
				else
					op = OP_RESERVED;
				send_cmd(op, pick_value(), pos);
			end
			burst_mode = 1'b0;
			// Let the pipeline run dry halfway through.
			if (seg == SEGMENTS / 2)
				wait_dump_idle();
		end

		wait_dump_idle();
		repeat (40) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("[bounded_ordered_list_unit] OK");
		end else begin
			$display("[bounded_ordered_list_unit] ERROR");
		end
		$finish;
	end

endmodule
